### sv/slds_pkg.sv
`timescale 1ns / 1ps

package slds_pkg;

    // Field and state widths
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int PHASE_BITS  = 24;
    localparam int AREA_BITS   = 48;
    localparam int HIST_BITS   = 40;
    localparam int COEF_BITS   = 24;
    localparam int GAIN_BITS   = 17;
    localparam int OUT_BITS    = 16;
    localparam int QUOT_BITS   = 48;

    // One input sample step in Q8.16 phase units
    localparam logic [PHASE_BITS-1:0] ONE_Q       = 24'h010000;
    localparam logic [PHASE_BITS-1:0] RATIO_RESET = 24'd681574;
    localparam logic [COEF_BITS-1:0]  COEF_RESET  = 24'd16772183;
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 17'd65536;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_RATIO = 3'd0,
        CFG_COEF1 = 3'd1,
        CFG_COEF2 = 3'd2,
        CFG_GAIN  = 3'd3,
        CFG_AVOID = 3'd4
    } cfg_index_t;

    // Settings shared by both lanes; ratio is already limited to at least 1.0
    typedef struct packed {
        logic [PHASE_BITS-1:0] ratio;
        logic [COEF_BITS-1:0]  coef1;
        logic [COEF_BITS-1:0]  coef2;
        logic [GAIN_BITS-1:0]  gain;
        logic                  avoid;
    } slds_cfg_t;

    // Command from the phase control to a lane
    typedef struct packed {
        logic                 acc;
        logic                 start;
        logic [FRAC_BITS:0]   frac;
    } slds_lane_cmd_t;

    // Lane status toward the control and the merge stage
    typedef struct packed {
        logic idle;
        logic done;
    } slds_lane_stat_t;

endpackage

### sv/slds_lane.sv
`timescale 1ns / 1ps

module slds_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slds_pkg::slds_cfg_t           cfg,
    input  slds_pkg::slds_lane_cmd_t      cmd,
    input  logic [15:0]                   sample,
    input  logic                          ack,
    output slds_pkg::slds_lane_stat_t     stat,
    output logic signed [15:0]            result
);
    import slds_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_MULD = 14'b00000000000010,
        ST_MID  = 14'b00000000000100,
        ST_SUM  = 14'b00000000001000,
        ST_MULP = 14'b00000000010000,
        ST_MULX = 14'b00000000100000,
        ST_ACC  = 14'b00000001000000,
        ST_DIV  = 14'b00000010000000,
        ST_PREP = 14'b00000100000000,
        ST_HI   = 14'b00001000000000,
        ST_LO   = 14'b00010000000000,
        ST_RND  = 14'b00100000000000,
        ST_UPD  = 14'b01000000000000,
        ST_DONE = 14'b10000000000000
    } lane_state_t;

    typedef enum logic [2:0] {
        STG_DC1  = 3'b001,
        STG_DC2  = 3'b010,
        STG_GAIN = 3'b100
    } lane_stage_t;

    localparam logic signed [HIST_BITS-1:0] SAT_MAX = 40'sh7FFFFFFFFF;
    localparam logic signed [HIST_BITS-1:0] SAT_MIN = 40'sh8000000000;
    localparam logic [5:0] DIV_LAST = 6'(QUOT_BITS - 1);

    lane_state_t state_reg, state_next;
    lane_stage_t stage_reg;
    logic [5:0]  cnt_reg;

    // Channel state kept across requests
    logic [SAMPLE_BITS-1:0]       prev_reg;
    logic [AREA_BITS-1:0]         area_reg;
    logic signed [HIST_BITS-1:0]  xin1_reg, y1_reg, xin2_reg, y2_reg;

    // Working registers of one period close
    logic [SAMPLE_BITS-1:0]       x_reg;
    logic [FRAC_BITS:0]           frac_reg, ofrac_reg;
    logic [31:0]                  mid_reg;
    logic [32:0]                  sp_reg, sx_reg;
    logic [AREA_BITS-1:0]         a_reg;
    logic [24:0]                  rem_reg;
    logic [QUOT_BITS-1:0]         quo_reg;
    logic signed [HIST_BITS-1:0]  xcur_reg;
    logic [HIST_BITS-1:0]         mag_reg;
    logic                         neg_reg;
    logic [63:0]                  acc_reg;
    logic [HIST_BITS-1:0]         rnd_reg;
    logic [56:0]                  prod_reg;
    logic signed [15:0]           result_reg;

    logic [32:0]                  mul_a;
    logic [23:0]                  mul_b;
    logic [23:0]                  mul_k;
    logic signed [16:0]           dx;
    logic [15:0]                  dabs;
    logic [31:0]                  prevq;
    logic [56:0]                  prod_rnd;
    logic [64:0]                  dividend;
    logic [25:0]                  r2;
    logic [25:0]                  dvs;
    logic [25:0]                  diff;
    logic                         ge;
    logic signed [HIST_BITS-1:0]  src;
    logic [63:0]                  full, full_dc, full_g;
    logic signed [41:0]           srnd, ysum;
    logic signed [HIST_BITS-1:0]  ysat;
    logic [14:0]                  clip;
    logic signed [15:0]           outv;
    logic [16:0]                  psum;
    logic signed [41:0]           xin_ext;
    logic signed [41:0]           ytot;

    // Interpolation helpers
    assign dx    = $signed({1'b0, x_reg}) - $signed({1'b0, prev_reg});
    assign dabs  = dx[16] ? 16'(-dx) : dx[15:0];
    assign prevq = {prev_reg, 16'b0};
    assign psum  = {1'b0, prev_reg} + {1'b0, sample};
    assign prod_rnd = prod_reg + 57'h8000;
    assign dividend = {1'b0, a_reg, 16'b0} + {41'b0, cfg.ratio};

    // Restoring divider step by twice the ratio
    assign r2   = {rem_reg, quo_reg[QUOT_BITS-1]};
    assign dvs  = {1'b0, cfg.ratio, 1'b0};
    assign ge   = (r2 >= dvs);
    assign diff = r2 - dvs;

    // Coefficient of the current blocker or gain step
    always_comb
    begin
        unique case (stage_reg)
            STG_DC1:  mul_k = cfg.coef1;
            STG_DC2:  mul_k = cfg.coef2;
            default:  mul_k = {7'b0, cfg.gain};
        endcase
    end

    always_comb
    begin
        unique case (stage_reg)
            STG_DC1:  src = y1_reg;
            STG_DC2:  src = y2_reg;
            default:  src = xcur_reg;
        endcase
    end

    // Shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MULD:
            begin
                mul_a = {17'b0, dabs};
                mul_b = {7'b0, frac_reg};
            end
            ST_MULP:
            begin
                mul_a = sp_reg;
                mul_b = {7'b0, frac_reg};
            end
            ST_MULX:
            begin
                mul_a = sx_reg;
                mul_b = {7'b0, ofrac_reg};
            end
            ST_HI:
            begin
                mul_a = {13'b0, mag_reg[39:20]};
                mul_b = mul_k;
            end
            ST_LO:
            begin
                mul_a = {13'b0, mag_reg[19:0]};
                mul_b = mul_k;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding of the multiply result and blocker update
    assign full    = acc_reg + {7'b0, prod_reg};
    assign full_dc = full + 64'h800000;
    assign full_g  = full + 64'h80000000;
    assign srnd    = neg_reg ? -$signed({2'b0, rnd_reg}) : $signed({2'b0, rnd_reg});
    assign ysum    = $signed({{2{xcur_reg[39]}}, xcur_reg}) + srnd;

    always_comb
    begin
        unique case (stage_reg)
            STG_DC1:  xin_ext = {{2{xin1_reg[39]}}, xin1_reg};
            STG_DC2:  xin_ext = {{2{xin2_reg[39]}}, xin2_reg};
            default:  xin_ext = '0;
        endcase
    end

    assign ytot = ysum - xin_ext;

    always_comb
    begin
        priority if (ytot > $signed({{2{SAT_MAX[39]}}, SAT_MAX}))
            ysat = SAT_MAX;
        else if (ytot < $signed({{2{SAT_MIN[39]}}, SAT_MIN}))
            ysat = SAT_MIN;
        else
            ysat = ytot[39:0];
    end

    // Gain result: clip, sign and optional zero replacement
    assign clip = (rnd_reg > 40'd32767) ? 15'h7FFF : rnd_reg[14:0];
    always_comb
    begin
        outv = neg_reg ? -$signed({1'b0, clip}) : $signed({1'b0, clip});
        if (cfg.avoid && outv == 16'sd0)
            outv = 16'sd1;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (cmd.start) state_next = ST_MULD;
            ST_MULD: state_next = ST_MID;
            ST_MID:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_MULP;
            ST_MULP: state_next = ST_MULX;
            ST_MULX: state_next = ST_ACC;
            ST_ACC:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == DIV_LAST) state_next = ST_PREP;
            ST_PREP: state_next = ST_HI;
            ST_HI:   state_next = ST_LO;
            ST_LO:   state_next = ST_RND;
            ST_RND:  state_next = ST_UPD;
            ST_UPD:  state_next = (stage_reg == STG_GAIN) ? ST_DONE : ST_PREP;
            ST_DONE: if (ack) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stage_reg <= STG_DC1;
            cnt_reg   <= '0;
            prev_reg  <= '0;
            area_reg  <= '0;
            xin1_reg  <= '0;
            y1_reg    <= '0;
            xin2_reg  <= '0;
            y2_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!cmd.start && cmd.acc)
                    begin
                        area_reg <= area_reg + {15'b0, psum, 16'b0};
                        prev_reg <= sample;
                    end
                end
                ST_SUM:  prev_reg <= x_reg;
                ST_ACC:
                begin
                    area_reg <= {7'b0, prod_rnd[56:16]};
                    cnt_reg  <= '0;
                end
                ST_DIV:
                begin
                    cnt_reg   <= cnt_reg + 6'd1;
                    stage_reg <= STG_DC1;
                end
                ST_UPD:
                begin
                    unique case (stage_reg)
                        STG_DC1:
                        begin
                            xin1_reg  <= xcur_reg;
                            y1_reg    <= ysat;
                            stage_reg <= STG_DC2;
                        end
                        STG_DC2:
                        begin
                            xin2_reg  <= xcur_reg;
                            y2_reg    <= ysat;
                            stage_reg <= STG_GAIN;
                        end
                        default: stage_reg <= STG_DC1;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= 57'(mul_a) * 57'(mul_b);
        unique case (state_reg)
            ST_IDLE:
            begin
                x_reg    <= sample;
                frac_reg <= cmd.frac;
            end
            ST_MID:
                mid_reg <= dx[16] ? prevq - prod_reg[31:0] : prevq + prod_reg[31:0];
            ST_SUM:
            begin
                sp_reg    <= {1'b0, prevq} + {1'b0, mid_reg};
                sx_reg    <= {1'b0, mid_reg} + {1'b0, x_reg, 16'b0};
                ofrac_reg <= 17'h10000 - frac_reg;
            end
            ST_MULX:
                a_reg <= area_reg + {7'b0, prod_rnd[56:16]};
            ST_ACC:
            begin
                rem_reg <= {8'b0, dividend[64:48]};
                quo_reg <= dividend[47:0];
            end
            ST_DIV:
            begin
                rem_reg <= ge ? diff[24:0] : r2[24:0];
                quo_reg <= {quo_reg[QUOT_BITS-2:0], ge};
            end
            ST_PREP:
            begin
                if (stage_reg == STG_DC1)
                    xcur_reg <= (quo_reg > {8'b0, SAT_MAX}) ? SAT_MAX : quo_reg[39:0];
                mag_reg <= src[39] ? 40'(-src) : src;
                neg_reg <= src[39];
            end
            ST_LO:
                acc_reg <= {prod_reg[43:0], 20'b0};
            ST_RND:
                rnd_reg <= (stage_reg == STG_GAIN) ? {8'b0, full_g[63:32]} : full_dc[63:24];
            ST_UPD:
            begin
                xcur_reg <= ysat;
                if (stage_reg == STG_GAIN)
                    result_reg <= outv;
            end
            default: ;
        endcase
    end

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign result    = result_reg;

endmodule

### sv/slds_merge.sv
`timescale 1ns / 1ps

module slds_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slds_pkg::slds_lane_stat_t     stat_l,
    input  slds_pkg::slds_lane_stat_t     stat_r,
    input  logic signed [15:0]            res_l,
    input  logic signed [15:0]            res_r,
    input  logic                          result_stall,
    output logic                          ack,
    output logic                          result_valid,
    output logic signed [15:0]            left_out,
    output logic signed [15:0]            right_out
);
    import slds_pkg::*;

    logic                        valid_reg;
    logic signed [OUT_BITS-1:0]  left_reg, right_reg;

    // Both lanes finished and the output register is free or being emptied
    assign ack = stat_l.done & stat_r.done & (!valid_reg | !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ack)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    // Pair the two channel results into one request
    always_ff @(posedge clk)
    begin
        if (ack)
        begin
            left_reg  <= res_l;
            right_reg <= res_r;
        end
    end

    assign result_valid = valid_reg;
    assign left_out     = left_reg;
    assign right_out    = right_reg;

endmodule

### sv/stereo_linear_downsampler_dc_block_unit.sv
`timescale 1ns / 1ps
// Stereo linear-interpolating downsampler with two cascaded DC blockers per
// channel. Each request carries an unsigned left and right sample; the block
// integrates trapezoid areas over an output period of downsample_ratio input
// samples, divides by twice the ratio, runs two DC blockers, scales by
// output_gain and rounds and clips to +-32767. Left and right run in two
// identical lanes side by side. A request that does not close a period only
// adds its trapezoid area and leaves the lanes idle. A request that closes a
// period keeps the lanes busy through interpolation, the restoring divider
// (one quotient bit per cycle for 48 quotient bits), the lane's shared
// multiplier for the two blockers and the gain, and the hand-off to the output
// register. The output register lets the next request in while a result waits.
// Configuration writes are taken at any time and must only be issued idle.

module stereo_linear_downsampler_dc_block_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic [15:0]        left_sample,
    input  logic [15:0]        right_sample,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import slds_pkg::*;

    logic [PHASE_BITS-1:0] ratio_reg;
    logic [COEF_BITS-1:0]  coef1_reg, coef2_reg;
    logic [GAIN_BITS-1:0]  gain_reg;
    logic                  avoid_reg;
    logic [PHASE_BITS-1:0] iphase_reg, nphase_reg;

    logic [PHASE_BITS-1:0] eff_ratio;
    logic [PHASE_BITS:0]   phs;
    logic                  boundary;
    logic signed [25:0]    tfrac;
    logic [FRAC_BITS:0]    frac;
    logic [25:0]           nphase_sum;
    logic                  accept;
    logic                  ack;

    slds_cfg_t       cfg;
    slds_lane_cmd_t  cmd;
    slds_lane_stat_t stat_l, stat_r;
    logic signed [15:0] res_l, res_r;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= RATIO_RESET;
            coef1_reg <= COEF_RESET;
            coef2_reg <= COEF_RESET;
            gain_reg  <= GAIN_RESET;
            avoid_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RATIO: ratio_reg <= cfg_data;
                CFG_COEF1: coef1_reg <= cfg_data;
                CFG_COEF2: coef2_reg <= cfg_data;
                CFG_GAIN:  gain_reg  <= cfg_data[GAIN_BITS-1:0];
                CFG_AVOID: avoid_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign eff_ratio = (ratio_reg < ONE_Q) ? ONE_Q : ratio_reg;

    assign cfg.ratio = eff_ratio;
    assign cfg.coef1 = coef1_reg;
    assign cfg.coef2 = coef2_reg;
    assign cfg.gain  = gain_reg;
    assign cfg.avoid = avoid_reg;

    // Phase tracking and period boundary detection
    assign sample_stall = !(stat_l.idle && stat_r.idle);
    assign accept       = sample_valid && !sample_stall;

    assign phs      = {1'b0, iphase_reg} + {1'b0, ONE_Q};
    assign boundary = (phs >= {1'b0, nphase_reg});
    assign tfrac    = $signed({2'b0, nphase_reg}) + $signed({2'b0, ONE_Q})
                      - $signed({1'b0, phs});
    assign frac     = (tfrac[25] || tfrac[24:0] > {8'b0, ONE_Q[FRAC_BITS:0]})
                      ? ONE_Q[FRAC_BITS:0] : tfrac[FRAC_BITS:0];
    assign nphase_sum = {2'b0, nphase_reg} + {2'b0, eff_ratio} - {1'b0, phs};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iphase_reg <= '0;
            nphase_reg <= RATIO_RESET;
        end
        else if (accept)
        begin
            if (boundary)
            begin
                iphase_reg <= '0;
                nphase_reg <= nphase_sum[PHASE_BITS-1:0];
            end
            else
            begin
                iphase_reg <= phs[PHASE_BITS-1:0];
            end
        end
    end

    assign cmd.acc   = accept && !boundary;
    assign cmd.start = accept && boundary;
    assign cmd.frac  = frac;

    // One lane per channel
    slds_lane u_lane_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cmd    (cmd),
        .sample (left_sample),
        .ack    (ack),
        .stat   (stat_l),
        .result (res_l)
    );

    slds_lane u_lane_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cmd    (cmd),
        .sample (right_sample),
        .ack    (ack),
        .stat   (stat_r),
        .result (res_r)
    );

    // Merge the lane results into the output register
    slds_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat_l       (stat_l),
        .stat_r       (stat_r),
        .res_l        (res_l),
        .res_r        (res_r),
        .result_stall (result_stall),
        .ack          (ack),
        .result_valid (result_valid),
        .left_out     (left_out),
        .right_out    (right_out)
    );

endmodule
